FILE: design/mem_stg_pkg.sv
// Shared constants for the MIPS memory stage: opcodes and the default store size.
`default_nettype none
package mem_stg_pkg;

  localparam int unsigned MEM_BYTES_DEF = 1024;

  localparam logic [5:0] OP_LW  = 6'h23;
  localparam logic [5:0] OP_LH  = 6'h21;
  localparam logic [5:0] OP_LHU = 6'h25;
  localparam logic [5:0] OP_LB  = 6'h20;
  localparam logic [5:0] OP_LBU = 6'h24;
  localparam logic [5:0] OP_SW  = 6'h2B;
  localparam logic [5:0] OP_SH  = 6'h29;
  localparam logic [5:0] OP_SB  = 6'h28;
  localparam logic [5:0] OP_JAL = 6'h03;

endpackage
`default_nettype wire

FILE: design/mips_memory_stage.sv
// Top level of the MIPS memory stage: error checks, big-endian loads and stores, writeback value.
`default_nettype none
// The stage takes one instruction per clock while in_stall_o is low: the byte-lane RAMs are
// read and stage 1 is loaded at the edge that accepts the item, and the result is registered as stage 1 advances.
// The data store is four byte-lane RAMs of ceil(MEM_BYTES/4) rows each, so a word access at
// any byte offset touches every lane once in a single cycle. After reset a clearing pass
// zeroes one row per cycle until all ceil(MEM_BYTES/4) rows are clear, and
// in_stall_o stays high until it is done. A load that follows a store reads the stored bytes.
module mips_memory_stage #(
  parameter int unsigned MEM_BYTES = mem_stg_pkg::MEM_BYTES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [5:0]         opcode_i,
  input  wire logic               read_enable_i,
  input  wire logic               write_enable_i,
  input  wire logic               reg_write_i,
  input  wire logic signed [31:0] byte_address_i,
  input  wire logic [31:0]        alu_value_i,
  input  wire logic [31:0]        store_bits_i,
  input  wire logic               bound_error_i,
  input  wire logic               misaligned_i,
  input  wire logic               stop_in_i,
  input  wire logic [4:0]         dest_reg_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [31:0]             result_value_o,
  output logic                    jal_flag_o,
  output logic                    stop_out_o,
  output logic                    err_address_o,
  output logic                    err_misalign_o,
  output logic [4:0]              dest_reg_out_o
);

  import mem_stg_pkg::*;

  localparam int unsigned DEPTH = (MEM_BYTES + 3) / 4;
  localparam int unsigned RW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned BW    = $clog2(MEM_BYTES + 4);

  typedef struct packed {
    logic        ok;
    logic        rw;
    logic        do_load;
    logic        do_jal;
    logic        e_addr;
    logic        e_mis;
    logic        stop;
    logic [5:0]  op;
    logic [1:0]  base_lo;
    logic [3:0]  lane_in;
    logic [31:0] alu;
    logic [4:0]  dest;
  } s1_t;

  // Clearing pass
  logic          clr_busy_q;
  logic [RW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_q      <= '0;
    end else if (clr_busy_q) begin
      if (clr_q == RW'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // Handshake
  logic s1_valid_q, s1_adv, accept;
  logic out_valid_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clr_busy_q || (s1_valid_q && !s1_adv);
  assign accept     = in_valid_i && !in_stall_o;

  // Decode and lane addressing at the accepting edge
  logic [31:0]         addr_u;
  logic                in_range, ok, is_load, is_store, do_load, do_store, do_jal;
  logic [2:0]          nb;
  logic [BW-1:0]       base;
  logic [3:0][1:0]     off;
  logic [3:0][BW-1:0]  baddr;
  logic [3:0][RW-1:0]  row;
  logic [3:0]          byte_use, byte_in;
  logic [3:0][31:0]    shifted;
  logic [3:0][7:0]     wbyte;

  always_comb begin
    addr_u   = $unsigned(byte_address_i);
    in_range = addr_u < 32'(MEM_BYTES);
    ok       = in_range && !bound_error_i && !misaligned_i;
    is_load  = opcode_i inside {OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU};
    is_store = opcode_i inside {OP_SW, OP_SH, OP_SB};
    do_load  = ok && read_enable_i && is_load;
    do_store = ok && !do_load && write_enable_i && is_store;
    do_jal   = ok && !do_load && !do_store && (opcode_i == OP_JAL);
    case (opcode_i)
      OP_LW, OP_SW:          nb = 3'd4;
      OP_LH, OP_LHU, OP_SH:  nb = 3'd2;
      default:               nb = 3'd1;
    endcase
    base = addr_u[BW-1:0];
    for (int b = 0; b < 4; b++) begin
      // Lane b holds byte number off[b] of the access.
      off[b]      = 2'(b) - base[1:0];
      baddr[b]    = base + BW'(off[b]);
      byte_use[b] = {1'b0, off[b]} < nb;
      byte_in[b]  = baddr[b] < BW'(MEM_BYTES);
      row[b]      = baddr[b][RW+1:2];
      shifted[b]  = store_bits_i << {off[b], 3'b000};
      wbyte[b]    = shifted[b][31:24];
    end
  end

  logic [3:0][7:0] rdata;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    logic          we;
    logic [RW-1:0] waddr;
    logic [7:0]    wdata;

    assign we    = clr_busy_q || (accept && do_store && byte_use[g] && byte_in[g]);
    assign waddr = clr_busy_q ? clr_q : row[g];
    assign wdata = clr_busy_q ? 8'h00 : wbyte[g];

    mem_stg_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .re_i    (accept && do_load),
      .raddr_i (row[g]),
      .rdata_o (rdata[g])
    );
  end

  // Stage 1 register
  s1_t s1_q, s1_d;

  always_comb begin
    s1_d.ok      = ok;
    s1_d.rw      = reg_write_i;
    s1_d.do_load = do_load;
    s1_d.do_jal  = do_jal;
    s1_d.e_addr  = !in_range || bound_error_i;
    s1_d.e_mis   = misaligned_i;
    s1_d.stop    = stop_in_i || !in_range || bound_error_i || misaligned_i;
    s1_d.op      = opcode_i;
    s1_d.base_lo = base[1:0];
    s1_d.lane_in = byte_in;
    s1_d.alu     = alu_value_i;
    s1_d.dest    = dest_reg_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept || (s1_valid_q && !s1_adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  // Load assembly and held result
  logic [31:0]     held_q, held_d, load_val;
  logic [3:0][7:0] by;
  logic [1:0]      bk;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      bk    = s1_q.base_lo + 2'(i);
      by[i] = s1_q.lane_in[bk] ? rdata[bk] : 8'h00;
    end
    case (s1_q.op)
      OP_LW:   load_val = {by[0], by[1], by[2], by[3]};
      OP_LH:   load_val = {{16{by[0][7]}}, by[0], by[1]};
      OP_LHU:  load_val = {16'h0000, by[0], by[1]};
      OP_LB:   load_val = {{24{by[0][7]}}, by[0]};
      default: load_val = {24'h000000, by[0]};
    endcase
    held_d = held_q;
    if (s1_q.ok) begin
      if (s1_q.rw) begin
        held_d = s1_q.alu;
      end
      if (s1_q.do_load) begin
        held_d = load_val;
      end else if (s1_q.do_jal) begin
        held_d = s1_q.alu;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        held_q <= held_d;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      result_value_o <= held_d;
      jal_flag_o     <= s1_q.do_jal;
      stop_out_o     <= s1_q.stop;
      err_address_o  <= s1_q.e_addr;
      err_misalign_o <= s1_q.e_mis;
      dest_reg_out_o <= s1_q.dest;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: design/mem_stg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module mem_stg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
